// ----- sv/acs_pkg.sv -----
// Shared types and constants for the affinity chunk scheduler.
package acs_pkg;

	localparam int MAX_WORKERS  = 16;
	localparam int ITER_BITS    = 16;
	localparam int WID_BITS     = $clog2(MAX_WORKERS);
	localparam int TC_BITS      = 5;
	localparam int STATUS_BITS  = 2;
	localparam int CFG_IDX_BITS = 2;
	localparam int DIVQ_BITS    = ITER_BITS + 1;
	localparam int DIV_CNT_BITS = $clog2(DIVQ_BITS + 1);

	localparam logic CMD_RESTART = 1'b0;
	localparam logic CMD_REQUEST = 1'b1;

	localparam logic [STATUS_BITS-1:0] ST_RESTART = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_GRANT   = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_EMPTY   = 2'd2;
	localparam logic [STATUS_BITS-1:0] ST_BAD_ID  = 2'd3;

	localparam logic [CFG_IDX_BITS-1:0] REG_ITER_COUNT   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_THREAD_COUNT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_CHUNK    = 2'd2;

	localparam logic [ITER_BITS-1:0] ITER_COUNT_RST   = ITER_BITS'(1024);
	localparam logic [TC_BITS-1:0]   THREAD_COUNT_RST = TC_BITS'(16);
	localparam logic [ITER_BITS-1:0] MIN_CHUNK_RST    = ITER_BITS'(16);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_RST_DIV  = 8'b0000_0010,
		S_RST_FILL = 8'b0000_0100,
		S_OWN      = 8'b0000_1000,
		S_SCAN     = 8'b0001_0000,
		S_DIV      = 8'b0010_0000,
		S_UPD      = 8'b0100_0000,
		S_OUT      = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic                 go;
		logic [DIVQ_BITS-1:0] dividend;
		logic [TC_BITS-1:0]   divisor;
	} div_req_t;

endpackage

// ----- sv/acs_div.sv -----
// Restoring divider, one quotient bit per cycle, small divisor.
module acs_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  acs_pkg::div_req_t             req,
	output logic                          done,
	output logic [acs_pkg::DIVQ_BITS-1:0] quotient
);
	import acs_pkg::*;

	logic                    busy_q;
	logic                    done_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic [DIVQ_BITS-1:0]    quo_q;
	logic [TC_BITS-1:0]      rem_q;
	logic [TC_BITS-1:0]      dsr_q;
	logic [TC_BITS:0]        trial;
	logic [TC_BITS:0]        diff;
	logic                    ge;

	assign trial = {rem_q, quo_q[DIVQ_BITS-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dsr_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_BITS'(DIVQ_BITS);
				quo_q  <= req.dividend;
				rem_q  <= '0;
				dsr_q  <= req.divisor;
			end else if (busy_q) begin
				// remainder stays below the divisor, so the top trial bit drops out
				rem_q <= ge ? diff[TC_BITS-1:0] : trial[TC_BITS-1:0];
				quo_q <= {quo_q[DIVQ_BITS-2:0], ge};
				cnt_q <= cnt_q - DIV_CNT_BITS'(1);
				if (cnt_q == DIV_CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- sv/affinity_chunk_scheduler_core.sv -----
// Affinity chunk scheduler: one item at a time, walking the worker table and a
// shared serial divider. A restart runs a 17-step divide for the block size,
// then writes one table entry per cycle over all 16 workers. A request whose
// worker id is out of range goes straight to the output; one whose worker still
// owns work divides that remainder. Otherwise it scans every active worker for
// the fullest block before the 17-step chunk divide, or ends with an empty result
// when that scan finds nothing. in_stall is high from acceptance until the result
// is loaded into the output register; a result may wait there while the next item
// is taken, and a held output stalls the sequencer before that load.
// Configuration writes take effect at once and belong in idle periods.
module affinity_chunk_scheduler_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [acs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [acs_pkg::ITER_BITS-1:0]       cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                cmd,
	input  logic [acs_pkg::WID_BITS-1:0]        worker_id,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [acs_pkg::STATUS_BITS-1:0]     status,
	output logic [acs_pkg::ITER_BITS-1:0]       chunk_start,
	output logic [acs_pkg::ITER_BITS-1:0]       chunk_end,
	output logic [acs_pkg::WID_BITS-1:0]        source_worker
);
	import acs_pkg::*;

	state_t                 state_q;
	logic [ITER_BITS-1:0]   iter_count_q;
	logic [TC_BITS-1:0]     thread_count_q;
	logic [ITER_BITS-1:0]   min_chunk_q;

	logic [ITER_BITS-1:0]   next_free_q [MAX_WORKERS];
	logic [ITER_BITS-1:0]   block_end_q [MAX_WORKERS];

	logic [WID_BITS-1:0]    idx_q;
	logic [WID_BITS-1:0]    pos_q;
	logic [TC_BITS-1:0]     t_q;
	logic [ITER_BITS-1:0]   best_q;
	logic                   found_q;
	logic [ITER_BITS-1:0]   rem_q;
	logic [ITER_BITS-1:0]   per_q;
	logic [ITER_BITS-1:0]   acc_q;
	logic [ITER_BITS-1:0]   chunk_q;
	div_req_t               div_req_q;

	logic [STATUS_BITS-1:0] res_status_q;
	logic [ITER_BITS-1:0]   res_start_q;
	logic [ITER_BITS-1:0]   res_end_q;
	logic [WID_BITS-1:0]    res_src_q;

	logic                   out_valid_q;
	logic [STATUS_BITS-1:0] out_status_q;
	logic [ITER_BITS-1:0]   out_start_q;
	logic [ITER_BITS-1:0]   out_end_q;
	logic [WID_BITS-1:0]    out_src_q;

	logic                   div_done;
	logic [DIVQ_BITS-1:0]   div_quo;

	logic [TC_BITS-1:0]     t_act;
	logic                   in_acc;
	logic                   out_free;
	logic [ITER_BITS-1:0]   rd_nf;
	logic [ITER_BITS-1:0]   rd_be;
	logic [ITER_BITS-1:0]   rd_rem;
	logic                   better;
	logic [ITER_BITS-1:0]   best_n;
	logic [WID_BITS-1:0]    pos_n;
	logic                   found_n;
	logic                   scan_last;
	logic [ITER_BITS:0]     fill_sum;
	logic [ITER_BITS-1:0]   fill_hi;
	logic                   fill_live;
	logic [ITER_BITS-1:0]   chunk_n;
	logic [ITER_BITS-1:0]   grant_end;
	logic                   wr_en;
	logic                   wr_be_en;
	logic [ITER_BITS-1:0]   wr_nf;
	logic [ITER_BITS-1:0]   wr_be;

	function automatic logic [DIVQ_BITS-1:0] ceil_num(
		input logic [ITER_BITS-1:0] x,
		input logic [TC_BITS-1:0]   t
	);
		ceil_num = DIVQ_BITS'(x) + DIVQ_BITS'(t) - DIVQ_BITS'(1);
	endfunction

	acs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		if (thread_count_q == '0) begin
			t_act = TC_BITS'(1);
		end else if (thread_count_q > TC_BITS'(MAX_WORKERS)) begin
			t_act = TC_BITS'(MAX_WORKERS);
		end else begin
			t_act = thread_count_q;
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// single table read port, addressed by the sequencer index
	assign rd_nf  = next_free_q[idx_q];
	assign rd_be  = block_end_q[idx_q];
	assign rd_rem = (rd_be > rd_nf) ? (rd_be - rd_nf) : '0;

	assign better    = rd_rem > best_q;
	assign best_n    = better ? rd_rem : best_q;
	assign pos_n     = better ? idx_q : pos_q;
	assign found_n   = found_q || better;
	assign scan_last = TC_BITS'(idx_q) == (t_q - TC_BITS'(1));

	// block bounds at restart: running end, clamped at the iteration count
	assign fill_sum  = {1'b0, acc_q} + {1'b0, per_q};
	assign fill_hi   = (fill_sum > {1'b0, iter_count_q}) ? iter_count_q
	                                                     : fill_sum[ITER_BITS-1:0];
	assign fill_live = TC_BITS'(idx_q) < t_q;

	always_comb begin
		if (min_chunk_q != '0 && div_quo < DIVQ_BITS'(min_chunk_q)) begin
			chunk_n = (rem_q >= min_chunk_q) ? min_chunk_q : rem_q;
		end else begin
			chunk_n = div_quo[ITER_BITS-1:0];
		end
	end

	assign grant_end = rd_nf + chunk_q;

	always_comb begin
		wr_en    = 1'b0;
		wr_be_en = 1'b0;
		wr_nf    = grant_end;
		wr_be    = '0;
		case (state_q)
			S_RST_FILL: begin
				wr_en    = 1'b1;
				wr_be_en = 1'b1;
				wr_nf    = fill_live ? acc_q : '0;
				wr_be    = fill_live ? fill_hi : '0;
			end
			S_UPD: begin
				wr_en = 1'b1;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_WORKERS; i++) begin
				next_free_q[i] <= '0;
				block_end_q[i] <= '0;
			end
		end else if (wr_en) begin
			next_free_q[idx_q] <= wr_nf;
			if (wr_be_en) begin
				block_end_q[idx_q] <= wr_be;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_count_q   <= ITER_COUNT_RST;
			thread_count_q <= THREAD_COUNT_RST;
			min_chunk_q    <= MIN_CHUNK_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ITER_COUNT:   iter_count_q   <= cfg_data;
				REG_THREAD_COUNT: thread_count_q <= cfg_data[TC_BITS-1:0];
				REG_MIN_CHUNK:    min_chunk_q    <= cfg_data;
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			pos_q        <= '0;
			t_q          <= TC_BITS'(1);
			best_q       <= '0;
			found_q      <= 1'b0;
			rem_q        <= '0;
			per_q        <= '0;
			acc_q        <= '0;
			chunk_q      <= '0;
			div_req_q    <= '0;
			res_status_q <= ST_RESTART;
			res_start_q  <= '0;
			res_end_q    <= '0;
			res_src_q    <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_RESTART;
			out_start_q  <= '0;
			out_end_q    <= '0;
			out_src_q    <= '0;
		end else begin
			// in S_OUT a taken result is replaced by the next one
			if (out_valid_q && !out_stall && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					div_req_q.go <= in_acc && (cmd == CMD_RESTART);
					if (in_acc) begin
						t_q          <= t_act;
						res_status_q <= ST_BAD_ID;
						res_start_q  <= '0;
						res_end_q    <= '0;
						res_src_q    <= '0;
						if (cmd == CMD_RESTART) begin
							div_req_q.dividend <= ceil_num(iter_count_q, t_act);
							div_req_q.divisor  <= t_act;
							state_q            <= S_RST_DIV;
						end else if (TC_BITS'(worker_id) >= t_act) begin
							state_q <= S_OUT;
						end else begin
							idx_q   <= worker_id;
							state_q <= S_OWN;
						end
					end
				end
				S_RST_DIV: begin
					div_req_q.go <= 1'b0;
					if (div_done) begin
						per_q   <= div_quo[ITER_BITS-1:0];
						acc_q   <= '0;
						idx_q   <= '0;
						state_q <= S_RST_FILL;
					end
				end
				S_RST_FILL: begin
					div_req_q.go <= 1'b0;
					if (fill_live) begin
						acc_q <= fill_hi;
					end
					idx_q <= idx_q + WID_BITS'(1);
					if (idx_q == WID_BITS'(MAX_WORKERS - 1)) begin
						res_status_q <= ST_RESTART;
						state_q      <= S_OUT;
					end
				end
				S_OWN: begin
					div_req_q.go <= (rd_rem != '0);
					if (rd_rem != '0) begin
						pos_q              <= idx_q;
						rem_q              <= rd_rem;
						div_req_q.dividend <= ceil_num(rd_rem, t_q);
						div_req_q.divisor  <= t_q;
						state_q            <= S_DIV;
					end else begin
						idx_q   <= '0;
						pos_q   <= '0;
						best_q  <= '0;
						found_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					div_req_q.go <= scan_last && found_n;
					best_q  <= best_n;
					pos_q   <= pos_n;
					found_q <= found_n;
					if (scan_last) begin
						if (found_n) begin
							idx_q              <= pos_n;
							rem_q              <= best_n;
							div_req_q.dividend <= ceil_num(best_n, t_q);
							div_req_q.divisor  <= t_q;
							state_q            <= S_DIV;
						end else begin
							res_status_q <= ST_EMPTY;
							state_q      <= S_OUT;
						end
					end else begin
						idx_q <= idx_q + WID_BITS'(1);
					end
				end
				S_DIV: begin
					div_req_q.go <= 1'b0;
					if (div_done) begin
						chunk_q <= chunk_n;
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					div_req_q.go <= 1'b0;
					res_status_q <= ST_GRANT;
					res_start_q  <= rd_nf;
					res_end_q    <= grant_end;
					res_src_q    <= pos_q;
					state_q      <= S_OUT;
				end
				S_OUT: begin
					div_req_q.go <= 1'b0;
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_start_q  <= res_start_q;
						out_end_q    <= res_end_q;
						out_src_q    <= res_src_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					div_req_q.go <= 1'b0;
					state_q      <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign chunk_start   = out_start_q;
	assign chunk_end     = out_end_q;
	assign source_worker = out_src_q;

`ifndef SYNTH
	a_zero_unless_grant: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_GRANT |->
			chunk_start == '0 && chunk_end == '0 && source_worker == '0)
		else $error("non-grant result carries chunk data");

	a_grant_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_GRANT |-> chunk_end > chunk_start)
		else $error("granted chunk is empty or wraps");

	a_div_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV || state_q == S_RST_DIV))
		else $error("divider finished outside a divide wait");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q != S_IDLE)
		else $error("accepted item did not start the sequencer");
`endif

endmodule
